/* rtl/doi_pkg.sv */
`default_nettype none
// Shared types, constants and the sine table builder for the oscillator integrator.
// No dependencies; every other file except doi_div3 imports this package.
package doi_pkg;

  localparam int FracBits     = 16;
  localparam int SineFracBits = 15;
  localparam int SineDepth    = 1024;
  localparam int SineAw       = $clog2(SineDepth);
  localparam int DataW        = 32;
  localparam int StepW        = 14;
  localparam int SumW         = 35;
  localparam int OpW          = 36;
  localparam int ProdW        = 68;
  localparam int TermW        = 54;
  localparam int SatW         = TermW + 2;
  localparam int CfgIdxW      = 3;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  localparam logic [CfgIdxW-1:0] RegMethod   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStiff    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDamp     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDrive    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPhaseInc = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDt       = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStartPos = 3'd6;
  localparam logic [CfgIdxW-1:0] RegStartVel = 3'd7;

  typedef logic signed [15:0] sine_tab_t [SineDepth];

  typedef struct packed {
    logic               method;
    logic signed [31:0] stiff;
    logic signed [31:0] damp;
    logic signed [31:0] drive;
    logic [31:0]        phase_inc;
    logic [30:0]        dt;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
  } cfg_t;

  typedef struct packed {
    logic             restart;
    logic [StepW-1:0] step_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [31:0]        elapsed_steps;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned u, quad, rem, r, x, x2, term;
    longint          sum;
    for (int i = 0; i < SineDepth; i++) begin
      u    = longint'(i) * 4;
      quad = u / SineDepth;
      rem  = u % SineDepth;
      r    = quad[0] ? SineDepth - rem : rem;
      x    = r * HalfPiQ30 / SineDepth;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      sum = (sum * 32767 + 64'sd536870912) >>> 30;
      tab[i] = (quad >= 2) ? -(16'(sum)) : 16'(sum);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

/* rtl/doi_in_if.sv */
`default_nettype none
// Request channel: valid/ready with restart flag and step count.
// Depends on doi_pkg.
interface doi_in_if import doi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/doi_out_if.sv */
`default_nettype none
// Result channel: valid/ready with position, velocity and elapsed steps.
// Depends on doi_pkg.
interface doi_out_if import doi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/doi_sine_rom.sv */
`default_nettype none
// Sine table with registered read, contents built at elaboration.
// Depends on doi_pkg.
module doi_sine_rom import doi_pkg::*; (
  input  logic                clk_i,
  input  logic [SineAw-1:0]   addr_i,
  output logic signed [15:0]  data_o
);
  localparam sine_tab_t SineTab = build_sine_tab();

  logic signed [15:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SineTab[addr_i];
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

/* rtl/doi_mac.sv */
`default_nettype none
// Shared two-pass multiplier: 36 x 17 bit per cycle, upper half then lower half,
// full product shifted right with floor. Depends on doi_pkg.
module doi_mac import doi_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [OpW-1:0]   a_i,
  input  logic signed [DataW-1:0] b_i,
  input  logic                    hi_phase_i,
  input  logic [4:0]              shift_i,
  output logic signed [TermW-1:0] term_o
);
  logic signed [16:0]      b_chunk;
  logic signed [OpW+16:0]  part;
  logic signed [ProdW-1:0] hi_q, full;

  assign b_chunk = hi_phase_i ? {b_i[DataW-1], b_i[DataW-1:16]} : {1'b0, b_i[15:0]};
  assign part    = a_i * b_chunk;
  assign full    = hi_q + ProdW'(part);
  assign term_o  = TermW'(full >>> shift_i);

  always_ff @(posedge clk_i) begin
    if (hi_phase_i) begin
      hi_q <= ProdW'(part) <<< 16;
    end
  end
endmodule
`default_nettype wire

/* rtl/doi_div3.sv */
`default_nettype none
// Divide by three, twelve quotient bits a cycle as three nibble digits.
// Depends on nothing.
module doi_div3 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [35:0] n_i,
  output logic        done_o,
  output logic [35:0] q_o
);
  logic        busy_q, busy_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [35:0] work_q;
  logic [1:0]  rem_q, rem_c;
  logic [23:0] quo_q;
  logic [11:0] chunk;
  logic [5:0]  t;
  logic [10:0] prod;
  logic [3:0]  qd;

  always_comb begin
    rem_c = rem_q;
    chunk = '0;
    t     = '0;
    prod  = '0;
    qd    = '0;
    for (int k = 0; k < 3; k++) begin
      t     = {rem_c, work_q[35-4*k -: 4]};
      prod  = 11'(t) * 11'd43;
      qd    = prod[10:7];
      rem_c = 2'(t - 6'(qd) * 6'd3);
      chunk[11-4*k -: 4] = qd;
    end
  end

  assign done_o = busy_q && (cnt_q == 2'd2);
  assign q_o    = {quo_q, chunk};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd2) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= n_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_q << 12;
      rem_q  <= rem_c;
      quo_q  <= {quo_q[11:0], chunk};
    end
  end
endmodule
`default_nettype wire

/* rtl/doi_core.sv */
`default_nettype none
// Step sequencer: Euler or RK4 steps on the shared multiplier, sine table and divider.
// Depends on doi_pkg, doi_mac, doi_sine_rom, doi_div3.
module doi_core import doi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             start_i,
  input  logic             restart_i,
  input  logic [StepW-1:0] steps_i,
  input  logic             take_i,
  output core_stat_t       stat_o,
  output out_item_t        res_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  localparam logic [2:0] OpKx = 3'd0;
  localparam logic [2:0] OpBv = 3'd1;
  localparam logic [2:0] OpFs = 3'd2;
  localparam logic [2:0] OpXh = 3'd3;
  localparam logic [2:0] OpVh = 3'd4;
  localparam logic [2:0] OpXf = 3'd5;
  localparam logic [2:0] OpVf = 3'd6;

  localparam longint DivLimL = 64'sd34359738368;
  localparam logic signed [TermW-1:0] DivLim = TermW'(DivLimL);

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] v);
    if (&v[SatW-1:DataW-1] || ~|v[SatW-1:DataW-1]) return v[DataW-1:0];
    else if (v[SatW-1]) return {1'b1, {(DataW-1){1'b0}}};
    else return {1'b0, {(DataW-1){1'b1}}};
  endfunction

  logic [1:0]             st_q, st_d;
  logic [2:0]             op_q, op_d;
  logic                   lo_q, lo_d;
  logic [1:0]             stage_q, stage_d;
  logic [StepW-1:0]       cnt_q, cnt_d;
  logic signed [DataW-1:0] x_q, x_d, v_q, v_d, xs_q, xs_d, vs_q, vs_d, a_q, a_d;
  logic signed [TermW-1:0] acc_q, acc_d;
  logic signed [SumW-1:0]  sv_q, sv_d, sa_q, sa_d;
  logic [31:0]            ph_q, ph_d, tot_q, tot_d;
  logic                   dneg_q, dneg_d;

  logic signed [OpW-1:0]   mac_a;
  logic signed [DataW-1:0] mac_b;
  logic [4:0]              mac_sh;
  logic signed [TermW-1:0] term;
  logic [31:0]             ph_rd;
  logic [SineAw-1:0]       rom_addr;
  logic signed [15:0]      sine;

  logic                    div_start, div_done;
  logic [35:0]             div_n, div_q;
  logic signed [36:0]      yc;
  logic [36:0]             mag;
  logic signed [SatW-1:0]  qs;
  logic signed [DataW-1:0] div_res, a_new, v_fin;
  logic                    fin, mid_stage;

  doi_mac u_mac (
    .clk_i      (clk_i),
    .a_i        (mac_a),
    .b_i        (mac_b),
    .hi_phase_i (!lo_q),
    .shift_i    (mac_sh),
    .term_o     (term)
  );

  doi_sine_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (sine)
  );

  doi_div3 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    unique case (stage_q)
      2'd0:    ph_rd = ph_q;
      2'd3:    ph_rd = ph_q + cfg_i.phase_inc;
      default: ph_rd = ph_q + (cfg_i.phase_inc >> 1);
    endcase
  end
  assign rom_addr = ph_rd[31 -: SineAw] + SineAw'(ph_rd[31-SineAw]);

  always_comb begin
    mac_a  = '0;
    mac_b  = {1'b0, cfg_i.dt};
    mac_sh = 5'(FracBits);
    unique case (op_q)
      OpKx: begin
        mac_a = OpW'(xs_q);
        mac_b = cfg_i.stiff;
      end
      OpBv: begin
        mac_a = OpW'(vs_q);
        mac_b = cfg_i.damp;
      end
      OpFs: begin
        mac_a  = OpW'(cfg_i.drive);
        mac_b  = DataW'(sine);
        mac_sh = 5'(SineFracBits);
      end
      OpXh: begin
        mac_a  = OpW'(vs_q);
        mac_sh = (stage_q == 2'd2) ? 5'(FracBits) : 5'(FracBits + 1);
      end
      OpVh: begin
        mac_a  = OpW'(a_q);
        mac_sh = (stage_q == 2'd2) ? 5'(FracBits) : 5'(FracBits + 1);
      end
      OpXf: mac_a = cfg_i.method ? OpW'(sv_q) : OpW'(vs_q);
      OpVf: mac_a = cfg_i.method ? OpW'(sa_q) : OpW'(a_q);
      default: ;
    endcase
  end

  always_comb begin
    if (term > DivLim) yc = 37'(DivLim);
    else if (term < -DivLim) yc = -37'(DivLim);
    else yc = 37'(term);
    mag   = term[TermW-1] ? 37'(-yc + 37'sd5) : 37'(yc);
    div_n = mag[36:1];
  end

  assign qs      = dneg_q ? -$signed(SatW'(div_q)) : $signed(SatW'(div_q));
  assign div_res = sat32(SatW'((op_q == OpXf) ? x_q : v_q) + qs);
  assign a_new   = sat32(SatW'(acc_q) + SatW'(term));
  assign mid_stage = (stage_q == 2'd1) || (stage_q == 2'd2);

  always_comb begin
    st_d    = st_q;
    op_d    = op_q;
    lo_d    = lo_q;
    stage_d = stage_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    v_d     = v_q;
    xs_d    = xs_q;
    vs_d    = vs_q;
    a_d     = a_q;
    acc_d   = acc_q;
    sv_d    = sv_q;
    sa_d    = sa_q;
    ph_d    = ph_q;
    tot_d   = tot_q;
    dneg_d  = dneg_q;
    div_start = 1'b0;
    fin     = 1'b0;
    v_fin   = v_q;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          if (restart_i) begin
            x_d   = cfg_i.start_pos;
            v_d   = cfg_i.start_vel;
            xs_d  = cfg_i.start_pos;
            vs_d  = cfg_i.start_vel;
            ph_d  = '0;
            tot_d = '0;
          end
          cnt_d   = steps_i;
          op_d    = OpKx;
          lo_d    = 1'b0;
          stage_d = '0;
          st_d    = (steps_i == '0) ? StDone : StMul;
        end
      end
      StMul: begin
        lo_d = ~lo_q;
        if (lo_q) begin
          unique case (op_q)
            OpKx: begin
              acc_d = -term;
              op_d  = OpBv;
            end
            OpBv: begin
              acc_d = acc_q - term;
              op_d  = OpFs;
            end
            OpFs: begin
              a_d  = a_new;
              sv_d = ((stage_q == 2'd0) ? '0 : sv_q)
                   + (mid_stage ? (SumW'(vs_q) <<< 1) : SumW'(vs_q));
              sa_d = ((stage_q == 2'd0) ? '0 : sa_q)
                   + (mid_stage ? (SumW'(a_new) <<< 1) : SumW'(a_new));
              op_d = (!cfg_i.method || stage_q == 2'd3) ? OpXf : OpXh;
            end
            OpXh: begin
              xs_d = sat32(SatW'(x_q) + SatW'(term));
              op_d = OpVh;
            end
            OpVh: begin
              vs_d    = sat32(SatW'(v_q) + SatW'(term));
              stage_d = stage_q + 2'd1;
              op_d    = OpKx;
            end
            OpXf: begin
              if (cfg_i.method) begin
                div_start = 1'b1;
                dneg_d    = term[TermW-1];
                st_d      = StDiv;
              end else begin
                x_d  = sat32(SatW'(x_q) + SatW'(term));
                op_d = OpVf;
              end
            end
            OpVf: begin
              if (cfg_i.method) begin
                div_start = 1'b1;
                dneg_d    = term[TermW-1];
                st_d      = StDiv;
              end else begin
                fin   = 1'b1;
                v_fin = sat32(SatW'(v_q) + SatW'(term));
              end
            end
            default: ;
          endcase
        end
      end
      StDiv: begin
        if (div_done) begin
          if (op_q == OpXf) begin
            x_d  = div_res;
            op_d = OpVf;
            st_d = StMul;
          end else begin
            fin   = 1'b1;
            v_fin = div_res;
          end
        end
      end
      StDone: begin
        if (take_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
    if (fin) begin
      v_d     = v_fin;
      vs_d    = v_fin;
      xs_d    = x_q;
      ph_d    = ph_q + cfg_i.phase_inc;
      tot_d   = tot_q + 32'd1;
      cnt_d   = cnt_q - StepW'(1);
      stage_d = '0;
      op_d    = OpKx;
      lo_d    = 1'b0;
      st_d    = (cnt_q == StepW'(1)) ? StDone : StMul;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      op_q    <= OpKx;
      lo_q    <= 1'b0;
      stage_q <= '0;
      cnt_q   <= '0;
      x_q     <= '0;
      v_q     <= '0;
      xs_q    <= '0;
      vs_q    <= '0;
      ph_q    <= '0;
      tot_q   <= '0;
    end else begin
      st_q    <= st_d;
      op_q    <= op_d;
      lo_q    <= lo_d;
      stage_q <= stage_d;
      cnt_q   <= cnt_d;
      x_q     <= x_d;
      v_q     <= v_d;
      xs_q    <= xs_d;
      vs_q    <= vs_d;
      ph_q    <= ph_d;
      tot_q   <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    acc_q  <= acc_d;
    sv_q   <= sv_d;
    sa_q   <= sa_d;
    dneg_q <= dneg_d;
  end

  assign stat_o.idle = (st_q == StIdle);
  assign stat_o.done = (st_q == StDone);
  assign res_o.position      = x_q;
  assign res_o.velocity      = v_q;
  assign res_o.elapsed_steps = tot_q;
endmodule
`default_nettype wire

/* rtl/driven_oscillator_integrator_top.sv */
`default_nettype none
// Top level: configuration registers, channel handshakes, result register, sequencer.
// Depends on doi_pkg, doi_in_if, doi_out_if, doi_core.
//
//  channel  dir  handshake            payload
//  req_i    in   valid/ready          restart, step_count
//  rsp_o    out  valid/ready          position, velocity, elapsed_steps
//  cfg      in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// Each product takes two passes through the single 36x17 multiplier; RK4 adds two
// divides by six per step. req_i.ready is low from acceptance until the result
// moves to the output register; a waiting result does not block the next item.
// Reset clears the state to zero and loads the register defaults.
module driven_oscillator_integrator_top import doi_pkg::*; #(
  parameter int MAX_STEPS = 16383
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  doi_in_if.sink             req_i,
  doi_out_if.source          rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i
);
  cfg_t             cfg_q, cfg_d;
  core_stat_t       stat;
  out_item_t        core_res, out_q;
  logic             out_vld_q, out_vld_d;
  logic             accept, take;
  logic [StepW-1:0] steps;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMethod:   cfg_d.method    = cfg_data_i[0];
        RegStiff:    cfg_d.stiff     = cfg_data_i;
        RegDamp:     cfg_d.damp      = cfg_data_i;
        RegDrive:    cfg_d.drive     = cfg_data_i;
        RegPhaseInc: cfg_d.phase_inc = cfg_data_i;
        RegDt:       cfg_d.dt        = cfg_data_i[30:0];
        RegStartPos: cfg_d.start_pos = cfg_data_i;
        RegStartVel: cfg_d.start_vel = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.method    <= 1'b1;
      cfg_q.stiff     <= 32'sd65536;
      cfg_q.damp      <= '0;
      cfg_q.drive     <= '0;
      cfg_q.phase_inc <= '0;
      cfg_q.dt        <= 31'd655;
      cfg_q.start_pos <= 32'sd65536;
      cfg_q.start_vel <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign req_i.ready = stat.idle;
  assign accept      = req_i.valid && stat.idle;
  assign steps = (32'(req_i.data.step_count) > 32'(MAX_STEPS)) ? StepW'(MAX_STEPS)
                                                               : req_i.data.step_count;
  assign take  = stat.done && (!out_vld_q || rsp_o.ready);

  doi_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .start_i   (accept),
    .restart_i (req_i.data.restart),
    .steps_i   (steps),
    .take_i    (take),
    .stat_o    (stat),
    .res_o     (core_res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (take) out_vld_d = 1'b1;
    else if (rsp_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else out_vld_q <= out_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= core_res;
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> rsp_o.valid && (rsp_o.data == $past(core_res)))
    else $error("result not loaded into output register");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done && out_vld_q && !rsp_o.ready |=> stat.done && $stable(core_res))
    else $error("finished result lost while output busy");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("ready after accepting an item");
endmodule
`default_nettype wire

/* test/tb_doi_checker.sv */
`timescale 1ns / 100ps
// Checker for the oscillator integrator: snoops the register port and both channels,
// predicts each result in fixed point and compares it. Depends on doi_pkg and the channel interfaces.
module tb_doi_checker import doi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  doi_in_if                  req,
  doi_out_if                 rsp,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam logic MethodEuler = 1'b0;
  localparam int   MaxSteps    = 16383;

  cfg_t        osc_cfg;
  longint      pos_q, vel_q;
  logic [31:0] phase_q, total_q;
  shortint     sine_lut [SineDepth];
  out_item_t   expected_states [$];

  initial begin
    longint unsigned u, quad, rem, r, x, x2, term;
    longint          sum;
    bit              add;
    for (int i = 0; i < SineDepth; i++) begin
      u    = longint'(i) * 4;
      quad = u / SineDepth;
      rem  = u % SineDepth;
      r    = quad[0] ? SineDepth - rem : rem;
      x    = r * 64'd1686629713 / SineDepth;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      add  = 0;
      for (int n = 3; n <= 13; n += 2) begin
        term = ((term * x2) >> 30) / longint'((n - 1) * n);
        sum  = add ? sum + longint'(term) : sum - longint'(term);
        add  = !add;
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      sum = (sum * 32767 + 64'sd536870912) >>> 30;
      sine_lut[i] = (quad >= 2) ? shortint'(-sum) : shortint'(sum);
    end
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_sixth(longint p);
    if (p >= 0) return p / 6;
    return -((-p + 5) / 6);
  endfunction

  function automatic longint times_dt(longint v, logic [30:0] h);
    longint hi, lo;
    hi = v * longint'(h[30:16]);
    lo = v * longint'(h[15:0]);
    return hi + (lo >>> 16);
  endfunction

  function automatic longint osc_accel(longint x, longint v, logic [31:0] ph);
    longint unsigned t;
    longint          kx, bv, fs;
    t  = {32'b0, ph} * 1024 + 64'h8000_0000;
    kx = (longint'(signed'(osc_cfg.stiff)) * x) >>> 16;
    bv = (longint'(signed'(osc_cfg.damp)) * v) >>> 16;
    fs = (longint'(signed'(osc_cfg.drive)) * longint'(sine_lut[t[41:32]])) >>> 15;
    return sat32(-kx - bv + fs);
  endfunction

  task automatic advance_one();
    logic [30:0] h;
    logic [31:0] pps, phm, phe;
    longint      x, v, nx, nv, a1, a2, a3, a4, x2, v2, x3, v3, x4, v4;
    h   = osc_cfg.dt;
    pps = osc_cfg.phase_inc;
    x   = pos_q;
    v   = vel_q;
    if (osc_cfg.method == MethodEuler) begin
      nv = sat32(v + times_dt(osc_accel(x, v, phase_q), h));
      nx = sat32(x + times_dt(v, h));
    end else begin
      phm = phase_q + (pps >> 1);
      phe = phase_q + pps;
      a1  = osc_accel(x, v, phase_q);
      x2  = sat32(x + (times_dt(v, h) >>> 1));
      v2  = sat32(v + (times_dt(a1, h) >>> 1));
      a2  = osc_accel(x2, v2, phm);
      x3  = sat32(x + (times_dt(v2, h) >>> 1));
      v3  = sat32(v + (times_dt(a2, h) >>> 1));
      a3  = osc_accel(x3, v3, phm);
      x4  = sat32(x + times_dt(v3, h));
      v4  = sat32(v + times_dt(a3, h));
      a4  = osc_accel(x4, v4, phe);
      nx  = sat32(x + floor_sixth(times_dt(v + 2 * v2 + 2 * v3 + v4, h)));
      nv  = sat32(v + floor_sixth(times_dt(a1 + 2 * a2 + 2 * a3 + a4, h)));
    end
    pos_q   = nx;
    vel_q   = nv;
    phase_q = phase_q + pps;
    total_q = total_q + 1;
  endtask

  task automatic integrate_steps(input in_item_t it);
    int unsigned n;
    out_item_t   res;
    n = it.step_count;
    if (it.restart) begin
      pos_q   = longint'(signed'(osc_cfg.start_pos));
      vel_q   = longint'(signed'(osc_cfg.start_vel));
      phase_q = '0;
      total_q = '0;
    end
    if (n > MaxSteps) n = MaxSteps;
    for (int unsigned i = 0; i < n; i++) advance_one();
    res.position      = 32'(pos_q);
    res.velocity      = 32'(vel_q);
    res.elapsed_steps = total_q;
    expected_states.push_back(res);
  endtask

  assign pending_o = expected_states.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      osc_cfg = '{method: 1'b1, stiff: 32'sd65536, damp: '0, drive: '0, phase_inc: '0,
                  dt: 31'd655, start_pos: 32'sd65536, start_vel: '0};
      pos_q   = 0;
      vel_q   = 0;
      phase_q = '0;
      total_q = '0;
      expected_states.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMethod:   osc_cfg.method    = cfg_data_i[0];
          RegStiff:    osc_cfg.stiff     = cfg_data_i;
          RegDamp:     osc_cfg.damp      = cfg_data_i;
          RegDrive:    osc_cfg.drive     = cfg_data_i;
          RegPhaseInc: osc_cfg.phase_inc = cfg_data_i;
          RegDt:       osc_cfg.dt        = cfg_data_i[30:0];
          RegStartPos: osc_cfg.start_pos = cfg_data_i;
          RegStartVel: osc_cfg.start_vel = cfg_data_i;
          default: ;
        endcase
      end
      if (req.valid && req.ready) integrate_steps(req.data);
      if (rsp.valid && rsp.ready) begin
        if (expected_states.size() == 0) begin
          $error("unexpected result item: position %0d", rsp.data.position);
          fail_count_o++;
        end else begin
          want = expected_states.pop_front();
          if (rsp.data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp.data.position);
            fail_count_o++;
          end
          if (rsp.data.velocity !== want.velocity) begin
            $error("velocity: expected %0d, got %0d", want.velocity, rsp.data.velocity);
            fail_count_o++;
          end
          if (rsp.data.elapsed_steps !== want.elapsed_steps) begin
            $error("elapsed_steps: expected %0d, got %0d", want.elapsed_steps,
                   rsp.data.elapsed_steps);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Top of the oscillator integrator testbench: clock, reset, register writes, request stimulus and back-pressure.
// Depends on doi_pkg, the channel interfaces, the block and tb_doi_checker.
module tb_top;
  import doi_pkg::*;

  localparam int unsigned CycleLimit = 10000000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DataW-1:0]   cfg_data;
  int                 fail_count, pending;
  int unsigned        cycles, items_sent;
  bit                 calm, hold_req;

  doi_in_if  req_if ();
  doi_out_if rsp_if ();

  driven_oscillator_integrator_top DUT (
    .clk_i(clk), .rst_ni(rst_n), .req_i(req_if), .rsp_o(rsp_if),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  tb_doi_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .req(req_if), .rsp(rsp_if),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_if.ready = 1'b0;
        repeat (20000) @(negedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(RegMethod, {31'b0, c.method});
    write_reg(RegStiff, c.stiff);
    write_reg(RegDamp, c.damp);
    write_reg(RegDrive, c.drive);
    write_reg(RegPhaseInc, c.phase_inc);
    write_reg(RegDt, {1'b0, c.dt});
    write_reg(RegStartPos, c.start_pos);
    write_reg(RegStartVel, c.start_vel);
  endtask

  task automatic send_item(input logic rs, input int unsigned n);
    req_if.data.restart    = rs;
    req_if.data.step_count = StepW'(n);
    req_if.valid           = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  task automatic settle();
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic int unsigned rand_steps();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(0, 12);
    if (pick < 97) return $urandom_range(13, 100);
    return $urandom_range(101, 400);
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.method    = 1'($urandom_range(0, 1));
    c.phase_inc = $urandom;
    c.start_pos = $urandom;
    c.start_vel = $urandom;
    if ($urandom_range(0, 1)) begin
      c.stiff     = $urandom_range(0, 32'h8_0000);
      c.damp      = $urandom_range(0, 32'h1_0000);
      c.drive     = $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
      c.dt        = 31'($urandom_range(1, 4000));
      c.start_pos = $signed(c.start_pos) >>> 12;
      c.start_vel = $signed(c.start_vel) >>> 12;
    end else begin
      c.stiff = $urandom;
      c.damp  = $urandom;
      c.drive = $urandom;
      c.dt    = 31'($urandom);
    end
    return c;
  endfunction

  initial begin
    cfg_t cfg;
    calm         = 0;
    hold_req     = 0;
    items_sent   = 0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rst_n        = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_item(1'b0, 0);
    send_item(1'b1, 0);
    send_item(1'b1, 1);
    send_item(1'b0, 5);
    send_item(1'b0, 0);
    send_item(1'b1, 3);
    settle();

    cfg = '{method: 1'b0, stiff: 32'h7FFF_FFFF, damp: 32'h8000_0000, drive: 32'h7FFF_FFFF,
            phase_inc: 32'hFFFF_FFFF, dt: 31'h7FFF_FFFF, start_pos: 32'h8000_0000,
            start_vel: 32'h7FFF_FFFF};
    load_cfg(cfg);
    send_item(1'b1, 1);
    send_item(1'b0, 2);
    send_item(1'b1, 3);
    settle();

    cfg = '{method: 1'b1, stiff: 32'h8000_0000, damp: 32'h7FFF_FFFF, drive: 32'h8000_0000,
            phase_inc: 32'h0, dt: 31'h0, start_pos: 32'h7FFF_FFFF, start_vel: 32'h8000_0000};
    load_cfg(cfg);
    send_item(1'b1, 2);
    cfg.dt = 31'h7FFF_FFFF;
    settle();
    load_cfg(cfg);
    send_item(1'b1, 1);
    send_item(1'b0, 4);
    settle();

    cfg = '{method: 1'b0, stiff: 32'sd262144, damp: 32'sd3000, drive: 32'sd65536,
            phase_inc: 32'h0100_0000, dt: 31'd655, start_pos: 32'sd65536, start_vel: 32'sd0};
    load_cfg(cfg);
    send_item(1'b1, 16383);
    send_item(1'b0, 1);
    settle();
    cfg.method = 1'b1;
    cfg.dt     = 31'd1310;
    load_cfg(cfg);
    send_item(1'b1, 50);
    send_item(1'b0, 9);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      load_cfg(rand_cfg());
      if (ph == 1) hold_req = 1;
      if (ph == 3) calm = 1;
      send_item(1'b1, rand_steps());
      for (int k = 1; k < 25; k++) send_item($urandom_range(0, 3) == 0, rand_steps());
      settle();
    end

    repeat (50) @(negedge clk);
    $display("Covered %0d requests: Euler and RK4, register extremes with saturation,",
             items_sent);
    $display("zero-step and restart requests, a full 16383-step run and output back-pressure.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* driven_oscillator_integrator_top.f */
rtl/doi_pkg.sv
rtl/doi_in_if.sv
rtl/doi_out_if.sv
rtl/doi_sine_rom.sv
rtl/doi_mac.sv
rtl/doi_div3.sv
rtl/doi_core.sv
rtl/driven_oscillator_integrator_top.sv
test/tb_doi_checker.sv
test/tb_top.sv
